### rtl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types, codes and constants of the multichannel receive demux.
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

  localparam int CHANNELS    = 512;
  localparam int BLOCK_BYTES = 256;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int LEN_W       = $clog2(BLOCK_BYTES + 1);
  localparam int MAXCH_W     = 10;

  // fifo word bit positions
  localparam int W_PARITY_BIT = 11;
  localparam int W_MARK_BIT   = 9;
  localparam int W_CTL_BIT    = 8;

  typedef enum logic [1:0] {
    CMD_FIFO     = 2'd0,
    CMD_DRAIN    = 2'd1,
    CMD_SET_OPEN = 2'd2,
    CMD_SET_BUF  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STORE   = 2'd0,
    KIND_BLOCK   = 2'd1,
    KIND_CLOSE   = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RSN_PARITY     = 3'd0,
    RSN_NO_CHANNEL = 3'd1,
    RSN_EMPTY_CTL  = 3'd2,
    RSN_CHAN_ZERO  = 3'd3,
    RSN_RANGE      = 3'd4
  } reason_e;

  typedef enum logic {
    REG_MAX_CHANNELS = 1'b0,
    REG_LISTENER     = 1'b1
  } reg_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [11:0] word;
    logic [8:0]  target_channel;
    logic        flag_value;
  } rx_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [8:0]  channel;
    logic [7:0]  data_byte;
    logic [7:0]  position;
    logic [8:0]  block_length;
    logic        block_is_control;
    reason_e     discard_reason;
    logic        last;
  } result_t;

  typedef struct packed {
    logic            open_we;
    logic            buf_we;
    logic [CH_W-1:0] addr;
    logic            value;
  } flag_wr_t;

  typedef struct packed {
    logic    valid;
    logic    two;
    result_t r0;
    result_t r1;
  } load_t;

  typedef struct packed {
    logic [MAXCH_W-1:0] max_channels;
    logic               listener_present;
  } cfg_t;

  function automatic result_t discard(logic [8:0] ch, reason_e rsn);
    result_t r;
    r                = '0;
    r.kind           = KIND_DISCARD;
    r.channel        = ch;
    r.discard_reason = rsn;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mrd_if.sv
// ----------------------------------------------------------------------------
// mrd_if
// Valid/ready channels for receive items and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrd_rx_if;
  import mrd_pkg::*;
  logic       valid;
  logic       ready;
  cmd_e       cmd;
  logic [11:0] word;
  logic [8:0] target_channel;
  logic       flag_value;

  modport source (output valid, cmd, word, target_channel, flag_value, input ready);
  modport sink   (input valid, cmd, word, target_channel, flag_value, output ready);
endinterface

interface mrd_res_if;
  import mrd_pkg::*;
  logic       valid;
  logic       ready;
  kind_e      kind;
  logic [8:0] channel;
  logic [7:0] data_byte;
  logic [7:0] position;
  logic [8:0] block_length;
  logic       block_is_control;
  reason_e    discard_reason;
  logic       last;

  modport source (output valid, kind, channel, data_byte, position, block_length,
                  block_is_control, discard_reason, last, input ready);
  modport sink   (input valid, kind, channel, data_byte, position, block_length,
                  block_is_control, discard_reason, last, output ready);
endinterface

`default_nettype wire

### rtl/mrd_cfg.sv
// ----------------------------------------------------------------------------
// mrd_cfg
// APB register file: channel limit and listener flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mrd_pkg::cfg_t     cfg_o
);
  import mrd_pkg::*;

  logic [MAXCH_W-1:0] max_q;
  logic               lst_q;
  logic               wr_en;
  reg_e               sel_reg;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign sel_reg = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAXCH_W'(CHANNELS);
      lst_q <= 1'b1;
    end else if (wr_en) begin
      case (sel_reg)
        REG_MAX_CHANNELS: max_q <= pwdata[MAXCH_W-1:0];
        REG_LISTENER:     lst_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_reg)
      REG_MAX_CHANNELS: prdata = {{(32-MAXCH_W){1'b0}}, max_q};
      REG_LISTENER:     prdata = {31'd0, lst_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.max_channels     = max_q;
  assign cfg_o.listener_present = lst_q;

endmodule

`default_nettype wire

### rtl/mrd_flag_mem.sv
// ----------------------------------------------------------------------------
// mrd_flag_mem
// Per-channel open and buffered flag memories with a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_flag_mem (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mrd_pkg::flag_wr_t       wr_i,
  input  wire logic                    rd_en_i,
  input  wire logic [mrd_pkg::CH_W-1:0] rd_addr_i,
  output logic                         rd_open_o,
  output logic                         rd_buf_o,
  output logic                         clear_done_o
);
  import mrd_pkg::*;

  logic           open_mem [CHANNELS];
  logic           buf_mem  [CHANNELS];
  logic [CH_W:0]  clr_q;
  logic           clr_busy;
  logic           rd_open_q;
  logic           rd_buf_q;

  assign clr_busy     = (clr_q != (CH_W+1)'(CHANNELS));
  assign clear_done_o = !clr_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_busy) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      open_mem[clr_q[CH_W-1:0]] <= 1'b0;
      buf_mem[clr_q[CH_W-1:0]]  <= 1'b0;
    end else begin
      if (wr_i.open_we) open_mem[wr_i.addr] <= wr_i.value;
      if (wr_i.buf_we)  buf_mem[wr_i.addr]  <= wr_i.value;
    end
    if (rd_en_i) begin
      rd_open_q <= open_mem[rd_addr_i];
      rd_buf_q  <= buf_mem[rd_addr_i];
    end
  end

  assign rd_open_o = rd_open_q;
  assign rd_buf_o  = rd_buf_q;

endmodule

`default_nettype wire

### rtl/mrd_core.sv
// ----------------------------------------------------------------------------
// mrd_core
// Input register, channel state and single-pass decode of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  mrd_rx_if.sink                        rx,
  input  wire mrd_pkg::cfg_t            cfg_i,
  input  wire logic                     clear_done_i,
  input  wire logic                     rd_open_i,
  input  wire logic                     rd_buf_i,
  input  wire logic                     res_free_i,
  output mrd_pkg::flag_wr_t             wr_o,
  output logic                          rd_en_o,
  output logic [mrd_pkg::CH_W-1:0]      rd_addr_o,
  output mrd_pkg::load_t                load_o
);
  import mrd_pkg::*;

  logic               s1_valid_q;
  rx_item_t           s1_q;
  logic               rx_fire;
  logic               advance;

  logic [8:0]         cur_q, cur_d;
  logic               sel_q, sel_d;
  logic [LEN_W-1:0]   plen_q, plen_d;
  logic               pctl_q, pctl_d;
  logic               cbuf_q, cbuf_d;

  logic               dlv;
  logic               have_main;
  result_t            dlv_r;
  result_t            main_r;
  logic [8:0]         mark_ch;
  logic [7:0]         wbyte;
  logic               tgt_ok;

  assign rx_fire  = rx.valid && rx.ready;
  assign rx.ready = clear_done_i && (!s1_valid_q || advance);
  assign tgt_ok   = ({1'b0, rx.target_channel} < MAXCH_W'(CHANNELS));

  assign rd_en_o      = rx_fire;
  assign rd_addr_o    = rx.word[CH_W-1:0];
  assign wr_o.open_we = rx_fire && tgt_ok && (rx.cmd == CMD_SET_OPEN);
  assign wr_o.buf_we  = rx_fire && tgt_ok && (rx.cmd == CMD_SET_BUF);
  assign wr_o.addr    = rx.target_channel[CH_W-1:0];
  assign wr_o.value   = rx.flag_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx.ready) begin
      s1_valid_q <= rx.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      s1_q.cmd            <= rx.cmd;
      s1_q.word           <= rx.word;
      s1_q.target_channel <= rx.target_channel;
      s1_q.flag_value     <= rx.flag_value;
    end
  end

  assign mark_ch = s1_q.word[8:0];
  assign wbyte   = s1_q.word[7:0];

  always_comb begin
    cur_d     = cur_q;
    sel_d     = sel_q;
    plen_d    = plen_q;
    pctl_d    = pctl_q;
    cbuf_d    = cbuf_q;
    dlv       = 1'b0;
    have_main = 1'b0;
    main_r    = '0;

    dlv_r                  = '0;
    dlv_r.kind             = KIND_BLOCK;
    dlv_r.channel          = cur_q;
    dlv_r.block_length     = 9'(plen_q);
    dlv_r.block_is_control = pctl_q;

    case (s1_q.cmd)
      CMD_FIFO: begin
        if (s1_q.word[W_PARITY_BIT]) begin
          have_main = 1'b1;
          main_r    = discard(sel_q ? cur_q : 9'd0, RSN_PARITY);
        end else if (!s1_q.word[W_MARK_BIT]) begin
          if (!sel_q) begin
            have_main = 1'b1;
            main_r    = discard(9'd0, RSN_NO_CHANNEL);
          end else if (s1_q.word[W_CTL_BIT] && (wbyte == 8'd0)) begin
            have_main = 1'b1;
            main_r    = discard(cur_q, RSN_EMPTY_CTL);
          end else begin
            have_main        = 1'b1;
            main_r.kind      = KIND_STORE;
            main_r.channel   = cur_q;
            main_r.data_byte = wbyte;
            if (s1_q.word[W_CTL_BIT]) begin
              dlv                     = (plen_q != '0);
              main_r.position         = 8'd0;
              main_r.block_is_control = 1'b1;
              plen_d                  = LEN_W'(1);
              pctl_d                  = 1'b1;
            end else if (plen_q >= LEN_W'(BLOCK_BYTES)) begin
              dlv                     = 1'b1;
              main_r.position         = 8'd0;
              main_r.block_is_control = 1'b0;
              plen_d                  = LEN_W'(1);
              pctl_d                  = 1'b0;
            end else begin
              main_r.position         = 8'(plen_q);
              main_r.block_is_control = pctl_q;
              plen_d                  = plen_q + 1'b1;
            end
          end
        end else if (!(sel_q && (cur_q == mark_ch))) begin
          dlv    = (plen_q != '0);
          plen_d = '0;
          pctl_d = 1'b0;
          sel_d  = 1'b0;
          cur_d  = '0;
          if (mark_ch == 9'd0) begin
            have_main = 1'b1;
            main_r    = discard(mark_ch, RSN_CHAN_ZERO);
          end else if (({1'b0, mark_ch} >= cfg_i.max_channels) ||
                       ({1'b0, mark_ch} >= MAXCH_W'(CHANNELS))) begin
            have_main = 1'b1;
            main_r    = discard(mark_ch, RSN_RANGE);
          end else if (!rd_open_i) begin
            if (cfg_i.listener_present) begin
              have_main      = 1'b1;
              main_r.kind    = KIND_CLOSE;
              main_r.channel = mark_ch;
            end
          end else begin
            sel_d  = 1'b1;
            cur_d  = mark_ch;
            cbuf_d = rd_buf_i;
          end
        end
      end
      CMD_DRAIN: begin
        if ((plen_q != '0) && sel_q && (!cbuf_q || pctl_q)) begin
          dlv    = 1'b1;
          plen_d = '0;
          pctl_d = 1'b0;
        end
      end
      CMD_SET_BUF: begin
        if (s1_q.target_channel == cur_q) begin
          cbuf_d = s1_q.flag_value;
        end
      end
      default: ;
    endcase
  end

  assign advance = s1_valid_q && (!(dlv || have_main) || res_free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      sel_q  <= 1'b0;
      plen_q <= '0;
      pctl_q <= 1'b0;
      cbuf_q <= 1'b0;
    end else if (advance) begin
      cur_q  <= cur_d;
      sel_q  <= sel_d;
      plen_q <= plen_d;
      pctl_q <= pctl_d;
      cbuf_q <= cbuf_d;
    end
  end

  always_comb begin
    load_o.valid   = advance && (dlv || have_main);
    load_o.two     = dlv && have_main;
    load_o.r0      = dlv ? dlv_r : main_r;
    load_o.r0.last = !(dlv && have_main);
    load_o.r1      = main_r;
    load_o.r1.last = 1'b1;
  end

endmodule

`default_nettype wire

### rtl/mrd_out_buf.sv
// ----------------------------------------------------------------------------
// mrd_out_buf
// Two-slot result register that presents the results of one item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mrd_pkg::load_t load_i,
  output logic                res_free_o,
  mrd_res_if.source           res
);
  import mrd_pkg::*;

  result_t    slot0_q;
  result_t    slot1_q;
  logic [1:0] cnt_q;
  logic       fire;

  assign res.valid  = (cnt_q != 2'd0);
  assign fire       = res.valid && res.ready;
  assign res_free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i.valid) begin
      cnt_q <= load_i.two ? 2'd2 : 2'd1;
    end else if (fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.valid) begin
      slot0_q <= load_i.r0;
      slot1_q <= load_i.r1;
    end else if (fire) begin
      slot0_q <= slot1_q;
    end
  end

  assign res.kind             = slot0_q.kind;
  assign res.channel          = slot0_q.channel;
  assign res.data_byte        = slot0_q.data_byte;
  assign res.position         = slot0_q.position;
  assign res.block_length     = slot0_q.block_length;
  assign res.block_is_control = slot0_q.block_is_control;
  assign res.discard_reason   = slot0_q.discard_reason;
  assign res.last             = slot0_q.last;

endmodule

`default_nettype wire

### rtl/multichannel_receive_demux.sv
// ----------------------------------------------------------------------------
// multichannel_receive_demux
// Splits a receive word stream into per-channel blocks, notices and discards.
// ----------------------------------------------------------------------------
//  channel   dir  beat                               handshake
//  rx_i      in   cmd, word, target_channel, flag    valid/ready
//  res_o     out  one result, last marks item end    valid/ready
//  apb       in   max_channels @0, listener @4       psel/penable, pready=1
//
//  one item a cycle unless its results wait for the result register; an item
//  with two results fills both slots, an item with none leaves them untouched
//  an item passes the input register and flag read, then the result register
//  after reset rx_i.ready stays low while the flag memories clear
//  a stalled res_o holds the pending item in the input register only
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_receive_demux (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mrd_rx_if.sink           rx_i,
  mrd_res_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mrd_pkg::*;

  cfg_t            cfg;
  flag_wr_t        flag_wr;
  logic            rd_en;
  logic [CH_W-1:0] rd_addr;
  logic            rd_open;
  logic            rd_buf;
  logic            clear_done;
  logic            res_free;
  load_t           load;

  mrd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mrd_flag_mem u_flag_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (flag_wr),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_open_o    (rd_open),
    .rd_buf_o     (rd_buf),
    .clear_done_o (clear_done)
  );

  mrd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx           (rx_i),
    .cfg_i        (cfg),
    .clear_done_i (clear_done),
    .rd_open_i    (rd_open),
    .rd_buf_i     (rd_buf),
    .res_free_i   (res_free),
    .wr_o         (flag_wr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .load_o       (load)
  );

  mrd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .res_free_o (res_free),
    .res        (res_o)
  );

endmodule

`default_nettype wire

### rtl/mrd_checker.sv
// ----------------------------------------------------------------------------
// mrd_checker
// Port-level checks of the demux result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       rx_valid_i,
  input wire logic       rx_ready_i,
  input wire logic       res_valid_i,
  input wire logic       res_ready_i,
  input wire logic [1:0] res_kind_i,
  input wire logic [8:0] res_channel_i,
  input wire logic [7:0] res_data_byte_i,
  input wire logic [8:0] res_block_length_i,
  input wire logic       res_last_i
);

  // stalled result beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i) &&
      $stable(res_channel_i) && $stable(res_data_byte_i) &&
      $stable(res_block_length_i) && $stable(res_last_i))
    else $error("result beat changed while stalled");

  // second result of an item follows right away
  a_second_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=> res_valid_i)
    else $error("missing second result of an item");

  // results appear only after an accepted item has passed the input register
  a_rise_after_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(rx_valid_i && rx_ready_i, 2))
    else $error("result without an accepted item");

endmodule

bind multichannel_receive_demux mrd_checker u_mrd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rx_valid_i         (rx_i.valid),
  .rx_ready_i         (rx_i.ready),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_kind_i         (res_o.kind),
  .res_channel_i      (res_o.channel),
  .res_data_byte_i    (res_o.data_byte),
  .res_block_length_i (res_o.block_length),
  .res_last_i         (res_o.last)
);

`default_nettype wire
